// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fird_pkg.sv
package fird_pkg;

    // payload and arithmetic widths
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int DIV_W      = 31;
    localparam int TAP_CNT_W  = 5;
    localparam int COEF_IDX_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIV_W;

    // default filter depth
    localparam int TAPS_DEFAULT = 16;

    // divider sequencing
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register reset values
    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(16);
    localparam logic [DIV_W-1:0]     DIVIDER_RESET   = DIV_W'(1);

    // command codes of an input transaction
    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_TAP_COUNT = 1'b0,
        REG_DIVIDER   = 1'b1
    } cfg_reg_t;

    typedef logic signed [DATA_W-1:0] data_t;

    // status of the serial divider
    typedef struct packed
    {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/fird_in_if.sv
interface fird_in_if;

    logic                              valid;
    logic                              ready;
    fird_pkg::cmd_t                    cmd;
    logic signed [fird_pkg::DATA_W-1:0] sample;
    logic [fird_pkg::COEF_IDX_W-1:0]    coef_index;
    logic signed [fird_pkg::DATA_W-1:0] coef_value;

    modport source
    (
        output valid, cmd, sample, coef_index, coef_value,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, sample, coef_index, coef_value,
        output ready
    );

endinterface

// File: rtl/fird_out_if.sv
interface fird_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [fird_pkg::DATA_W-1:0] result;

    modport source
    (
        output valid, result,
        input  ready
    );

    modport sink
    (
        input  valid, result,
        output ready
    );

endinterface

// File: rtl/fir_filter_int32_divided.sv
// channel   dir   handshake      payload
// in_ch     in    valid/ready    cmd, sample, coef_index, coef_value
// out_ch    out   valid/ready    result
// cfg       in    cfg_we         cfg_idx, cfg_data
//
// a coefficient write gives no result
// a sample takes one multiply-accumulate per active tap off the history and
//   coefficient memories, then a pass through the bit-serial 64-by-31 divider
// one transaction is in work at a time; a finished result waits in the output
//   register while the next transaction is accepted
// rst_n clears the history at once through per-entry valid bits, no clearing pass

`include "assert_macros.svh"

module fir_filter_int32_divided
#(
    parameter int TAPS = fird_pkg::TAPS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    fird_in_if.sink                             in_ch,
    fird_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  fird_pkg::cfg_reg_t                  cfg_idx,
    input  logic [fird_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = ($clog2(TAPS + 1) > fird_pkg::TAP_CNT_W) ? $clog2(TAPS + 1)
                                                                    : fird_pkg::TAP_CNT_W;

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_MAC    = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [fird_pkg::TAP_CNT_W-1:0] tap_count_reg;
    logic [fird_pkg::DIV_W-1:0]     divider_reg;

    // memories
    fird_pkg::data_t hist_mem [TAPS];
    fird_pkg::data_t coef_mem [TAPS];
    logic [TAPS-1:0] hist_vld_reg;

    // sequencer and pipeline
    logic             issue_act_reg;
    logic [TAP_W-1:0] issue_idx_reg;
    logic             p1_vld_reg;
    logic [TAP_W-1:0] p1_idx_reg;
    logic             p2_vld_reg;
    fird_pkg::data_t  sample_reg;
    fird_pkg::data_t  hist_rd_reg;
    logic             hist_rd_vld_reg;
    fird_pkg::data_t  coef_rd_reg;
    logic signed [fird_pkg::ACC_W-1:0] prod_reg;
    logic [fird_pkg::ACC_W-1:0]        acc_reg;

    // output register
    logic             out_vld_reg;
    fird_pkg::data_t  out_result_reg;

    logic                         in_acc;
    logic                         coef_we;
    logic [CNT_W-1:0]             tc_ext;
    logic [CNT_W-1:0]             n_act;
    logic [TAP_W-1:0]             last_idx;
    logic [TAP_W-1:0]             hist_rd_addr;
    fird_pkg::data_t              new_val;
    logic signed [fird_pkg::ACC_W-1:0] prod_next;
    logic                         mac_done;
    logic                         div_start;
    logic [fird_pkg::ACC_W-1:0]   mag;
    logic [fird_pkg::DIV_W-1:0]   div_eff;
    logic [fird_pkg::DATA_W-1:0]  div_q;
    fird_pkg::div_status_t        div_st;
    logic                         out_load;

    // handshake
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign coef_we     = in_acc && (in_ch.cmd == fird_pkg::CMD_COEF)
                         && (32'(in_ch.coef_index) < TAPS);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fird_pkg::TAP_COUNT_RESET;
            divider_reg   <= fird_pkg::DIVIDER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                fird_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[fird_pkg::TAP_CNT_W-1:0];
                fird_pkg::REG_DIVIDER:   divider_reg   <= cfg_data;
            endcase
        end
    end

    // active tap count, clamped to 1..TAPS
    always_comb
    begin
        tc_ext = CNT_W'(tap_count_reg);
        if (tc_ext == '0)
            n_act = CNT_W'(1);
        else if (tc_ext > CNT_W'(TAPS))
            n_act = CNT_W'(TAPS);
        else
            n_act = tc_ext;
    end
    assign last_idx = TAP_W'(n_act - CNT_W'(1));

    // state machine
    assign mac_done  = (state_reg == ST_MAC) && !issue_act_reg && !p1_vld_reg && !p2_vld_reg;
    assign div_start = mac_done;
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_acc && (in_ch.cmd == fird_pkg::CMD_SAMPLE))
                        state_reg <= ST_MAC;
                ST_MAC:
                    if (mac_done)
                        state_reg <= ST_DIVIDE;
                ST_DIVIDE:
                    if (div_st.done)
                        state_reg <= ST_DONE;
                ST_DONE:
                    if (out_load)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // tap sequencer, walks from the oldest active tap down to tap 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_act_reg <= 1'b0;
            issue_idx_reg <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= issue_act_reg;
            p2_vld_reg <= p1_vld_reg;
            if (in_acc && (in_ch.cmd == fird_pkg::CMD_SAMPLE))
            begin
                issue_act_reg <= 1'b1;
                issue_idx_reg <= last_idx;
            end
            else if (issue_act_reg)
            begin
                issue_idx_reg <= issue_idx_reg - TAP_W'(1);
                if (issue_idx_reg == '0)
                    issue_act_reg <= 1'b0;
            end
        end
    end

    // tap k takes the old value of tap k-1; reads always run below the write address
    assign hist_rd_addr = (issue_idx_reg == '0) ? '0 : issue_idx_reg - TAP_W'(1);

    // history memory: read one below, write back shifted
    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[hist_rd_addr];
        if (p1_vld_reg)
            hist_mem[p1_idx_reg] <= new_val;
    end

    // history valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_vld_reg <= '0;
        else if (p1_vld_reg)
            hist_vld_reg[p1_idx_reg] <= 1'b1;
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        coef_rd_reg <= coef_mem[issue_idx_reg];
        if (coef_we)
            coef_mem[TAP_W'(in_ch.coef_index)] <= in_ch.coef_value;
    end

    // read-side pipeline payload
    always_ff @(posedge clk)
    begin
        hist_rd_vld_reg <= hist_vld_reg[hist_rd_addr];
        p1_idx_reg      <= issue_idx_reg;
        if (in_acc && (in_ch.cmd == fird_pkg::CMD_SAMPLE))
            sample_reg <= in_ch.sample;
    end

    // shifted-in value and product
    always_comb
    begin
        if (p1_idx_reg == '0)
            new_val = sample_reg;
        else if (hist_rd_vld_reg)
            new_val = hist_rd_reg;
        else
            new_val = '0;
        prod_next = new_val * coef_rd_reg;
    end

    // multiply and accumulate, wrapping at 64 bits
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_acc && (in_ch.cmd == fird_pkg::CMD_SAMPLE))
            acc_reg <= '0;
        else if (p2_vld_reg)
            acc_reg <= acc_reg + prod_reg;
    end

    // magnitude and divisor into the serial divider
    assign mag     = acc_reg[fird_pkg::ACC_W-1] ? (fird_pkg::ACC_W'(0) - acc_reg) : acc_reg;
    assign div_eff = (divider_reg == '0) ? fird_pkg::DIV_W'(1) : divider_reg;

    fird_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .neg      (acc_reg[fird_pkg::ACC_W-1]),
        .divisor  (div_eff),
        .quotient (div_q),
        .status   (div_st)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (out_ch.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_result_reg <= div_q;
    end

    assign out_ch.valid  = out_vld_reg;
    assign out_ch.result = out_result_reg;

    `ASSERT_IMPLY(a_idle_quiet, clk, rst_n, in_ch.ready,
                  !issue_act_reg && !p1_vld_reg && !p2_vld_reg && !div_st.busy,
                  "work in flight while accepting")
    `ASSERT_IMPLY(a_done_in_divide, clk, rst_n, div_st.done, state_reg == ST_DIVIDE,
                  "divider done outside divide state")
    `ASSERT_NEXT(a_sample_starts, clk, rst_n,
                 in_acc && (in_ch.cmd == fird_pkg::CMD_SAMPLE),
                 state_reg == ST_MAC && issue_act_reg, "sample did not start the tap walk")
    `ASSERT_IMPLY(a_tap_range, clk, rst_n, p1_vld_reg, p1_idx_reg <= last_idx,
                  "history write beyond active taps")

endmodule

// File: rtl/fird_div.sv
`include "assert_macros.svh"

module fird_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fird_pkg::ACC_W-1:0]       dividend,
    input  logic                             neg,
    input  logic [fird_pkg::DIV_W-1:0]       divisor,
    output logic [fird_pkg::DATA_W-1:0]      quotient,
    output fird_pkg::div_status_t            status
);

    logic [fird_pkg::DIV_W-1:0]  rem_reg;
    logic [fird_pkg::ACC_W-1:0]  quo_reg;
    logic [fird_pkg::DIV_W-1:0]  divisor_reg;
    logic                        neg_reg;
    logic [fird_pkg::STEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [fird_pkg::DIV_W:0]    trial;
    logic [fird_pkg::DIV_W:0]    diff;
    logic                        fits;

    // one restoring step: bring down the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[fird_pkg::ACC_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= fird_pkg::STEP_W'(fird_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - fird_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
            neg_reg     <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[fird_pkg::DIV_W-1:0] : trial[fird_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[fird_pkg::ACC_W-2:0], fits};
        end
    end

    // sign restore on the low word only
    assign quotient = neg_reg ? (fird_pkg::DATA_W'(0) - quo_reg[fird_pkg::DATA_W-1:0])
                              : quo_reg[fird_pkg::DATA_W-1:0];

    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `ASSERT_NEXT(a_div_starts, clk, rst_n, start && !busy_reg, busy_reg, "divider did not start")
    `ASSERT_IMPLY(a_div_nonzero, clk, rst_n, busy_reg, divisor_reg != '0, "divide by zero")
    `ASSERT_NEXT(a_div_done_pulse, clk, rst_n, done_reg, !done_reg && !busy_reg,
                 "done is not a single pulse")

endmodule
